@@ rtl/core/bgpf_pkg.sv @@
// Shared types, constants and address helpers for the background tile pixel fetch.
// No dependencies; used by scoped name in every other file of the block but bgpf_ram.
package bgpf_pkg;

   // Video memory geometry: two byte banks, even and odd addresses
   localparam int unsigned VRAM_BYTES  = 8192;
   localparam int unsigned VRAM_AW     = $clog2(VRAM_BYTES);
   localparam int unsigned BANK_DEPTH  = VRAM_BYTES / 2;
   localparam int unsigned BANK_AW     = $clog2(BANK_DEPTH);
   localparam int unsigned BYTE_W      = 8;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_X         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_Y         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_SELECT       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_DATA_SELECT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_PALETTE       = 3'd4;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Upper address bits shared by both tile maps (0x1800 and 0x1C00)
   localparam logic [1:0] MAP_REGION_TAG = 2'b11;

   // Grey levels for the four shades
   localparam logic [7:0] GREY_SHADE0 = 8'd255;
   localparam logic [7:0] GREY_SHADE1 = 8'd170;
   localparam logic [7:0] GREY_SHADE2 = 8'd85;
   localparam logic [7:0] GREY_SHADE3 = 8'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_PLANE
   } state_type;

   // Bank index of the map byte; bank itself is scrolled x bit 3
   function automatic logic [BANK_AW-1:0] map_index(input logic       map_sel,
                                                    input logic [7:0] y,
                                                    input logic [7:0] x);
      map_index = {MAP_REGION_TAG, map_sel, y[7:3], x[7:4]};
   endfunction

   // Bank index of a tile row; the low plane sits in the even bank, high in the odd.
   // Signed tiles at 0x1000 flip the top bit relative to the tile's sign.
   function automatic logic [BANK_AW-1:0] tile_row_index(input logic       unsigned_sel,
                                                         input logic [7:0] tile,
                                                         input logic [2:0] row);
      logic top;
      top = unsigned_sel ? 1'b0 : ~tile[7];
      tile_row_index = {top, tile, row};
   endfunction

   function automatic logic [7:0] grey_level(input logic [1:0] shade);
      logic [7:0] level;
      unique case (shade)
         2'd0:    level = GREY_SHADE0;
         2'd1:    level = GREY_SHADE1;
         2'd2:    level = GREY_SHADE2;
         default: level = GREY_SHADE3;
      endcase
      grey_level = level;
   endfunction

endpackage

@@ rtl/core/bgpf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for both video memory banks.
module bgpf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/background_tile_pixel_fetch_unit.sv @@
// Background tile pixel fetch: a write item is stored when accepted; a query item passes
// a map byte read, a bitplane read and the result register in turn, set by the two
// dependent video RAM reads; the result load waits while a stalled result is held.
// Queries run one at a time; a finished result waits in the output register.
// Synchronous reset clears control state and the configuration registers
// (tile_data_select to 1); video memory is not cleared and reads garbage until written.
module background_tile_pixel_fetch_unit (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [bgpf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wr_data,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [12:0]                      req_mem_address,
   input  logic [7:0]                       req_mem_data,
   input  logic [7:0]                       req_screen_line,
   input  logic [7:0]                       req_screen_column,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_color_index,
   output logic [1:0]                       rsp_shade,
   output logic [7:0]                       rsp_brightness
);

   // Configuration registers
   logic [7:0] scroll_x_ff, scroll_y_ff, bg_palette_ff;
   logic       map_select_ff, tile_data_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff         <= '0;
         scroll_y_ff         <= '0;
         map_select_ff       <= 1'b0;
         tile_data_select_ff <= 1'b1;
         bg_palette_ff       <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bgpf_pkg::CSR_SCROLL_X:         scroll_x_ff         <= csr_wr_data;
            bgpf_pkg::CSR_SCROLL_Y:         scroll_y_ff         <= csr_wr_data;
            bgpf_pkg::CSR_MAP_SELECT:       map_select_ff       <= csr_wr_data[0];
            bgpf_pkg::CSR_TILE_DATA_SELECT: tile_data_select_ff <= csr_wr_data[0];
            bgpf_pkg::CSR_BG_PALETTE:       bg_palette_ff       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Control state
   bgpf_pkg::state_type state_ff, state_in;
   logic       req_accept, accept_write, accept_query;
   logic       map_read, plane_read, load_out;

   // Query context carried across the reads
   logic [3:0] x_low_ff, x_low_in;
   logic [2:0] row_ff, row_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] color_ff, shade_ff;
   logic [7:0] bright_ff;

   // Memory ports
   logic [bgpf_pkg::BANK_AW-1:0] rd_index, wr_index;
   logic                         even_wr_en, odd_wr_en, even_rd_en, odd_rd_en;
   logic [7:0]                   even_rd_data, odd_rd_data;

   logic [7:0] y_scrolled, x_scrolled, tile;
   logic       lo_bit, hi_bit;
   logic [1:0] color_idx, shade_sel;

   assign req_accept   = req_valid && !req_stall;
   assign accept_write = req_accept && (req_kind == bgpf_pkg::KIND_WRITE);
   assign accept_query = req_accept && (req_kind == bgpf_pkg::KIND_QUERY);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgpf_pkg::ST_IDLE:  if (accept_query) state_in = bgpf_pkg::ST_MAP;
         bgpf_pkg::ST_MAP:   state_in = bgpf_pkg::ST_PLANE;
         bgpf_pkg::ST_PLANE: if (!rsp_valid_ff || !rsp_stall) state_in = bgpf_pkg::ST_IDLE;
         default:            state_in = bgpf_pkg::ST_IDLE;
      endcase
   end

   // Controls per state; idle never stalls, so a valid query is taken there
   always_comb begin
      req_stall  = 1'b1;
      map_read   = 1'b0;
      plane_read = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         bgpf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            map_read  = req_valid && (req_kind == bgpf_pkg::KIND_QUERY);
         end
         bgpf_pkg::ST_MAP: begin
            plane_read = 1'b1;
         end
         bgpf_pkg::ST_PLANE: begin
            load_out = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scroll the query coordinate with wrap at 256
   assign y_scrolled = req_screen_line + scroll_y_ff;
   assign x_scrolled = req_screen_column + scroll_x_ff;

   // Hold the pixel position inside the tile for the later stages
   assign x_low_in = map_read ? x_scrolled[3:0] : x_low_ff;
   assign row_in   = map_read ? y_scrolled[2:0] : row_ff;

   always_ff @(posedge clock) begin
      x_low_ff <= x_low_in;
      row_ff   <= row_in;
   end

   // Map byte comes from the bank chosen by x bit 3
   assign tile = x_low_ff[3] ? odd_rd_data : even_rd_data;

   // Writes and reads never overlap: writes are taken only in idle, and a
   // query blocks the request channel until its reads have finished.
   assign wr_index   = req_mem_address[bgpf_pkg::VRAM_AW-1:1];
   assign even_wr_en = accept_write && !req_mem_address[0];
   assign odd_wr_en  = accept_write &&  req_mem_address[0];

   assign rd_index = plane_read
                   ? bgpf_pkg::tile_row_index(tile_data_select_ff, tile, row_ff)
                   : bgpf_pkg::map_index(map_select_ff, y_scrolled, x_scrolled);
   assign even_rd_en = plane_read || (map_read && !x_scrolled[3]);
   assign odd_rd_en  = plane_read || (map_read &&  x_scrolled[3]);

   bgpf_ram #(
      .WIDTH (bgpf_pkg::BYTE_W),
      .DEPTH (bgpf_pkg::BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_wr_en),
      .wr_addr (wr_index),
      .wr_data (req_mem_data),
      .rd_en   (even_rd_en),
      .rd_addr (rd_index),
      .rd_data (even_rd_data)
   );

   bgpf_ram #(
      .WIDTH (bgpf_pkg::BYTE_W),
      .DEPTH (bgpf_pkg::BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_wr_en),
      .wr_addr (wr_index),
      .wr_data (req_mem_data),
      .rd_en   (odd_rd_en),
      .rd_addr (rd_index),
      .rd_data (odd_rd_data)
   );

   // Pick the pixel bit, leftmost pixel in bit 7, then map through the palette
   assign lo_bit    = even_rd_data[~x_low_ff[2:0]];
   assign hi_bit    = odd_rd_data[~x_low_ff[2:0]];
   assign color_idx = {hi_bit, lo_bit};
   assign shade_sel = 2'(bg_palette_ff >> {color_idx, 1'b0});

   // Result register: load when empty or being drained
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         color_ff  <= color_idx;
         shade_ff  <= shade_sel;
         bright_ff <= bgpf_pkg::grey_level(shade_sel);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = color_ff;
   assign rsp_shade       = shade_ff;
   assign rsp_brightness  = bright_ff;

endmodule

@@ rtl/core/bgpf_checker.sv @@
// Port-level checks for the background tile pixel fetch, bound to its top level.
// Depends on bgpf_pkg for item kinds and grey levels.
module bgpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_kind,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_color_index,
   input logic [1:0] rsp_shade,
   input logic [7:0] rsp_brightness
);

   // A stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_color_index)
                                 && $stable(rsp_shade) && $stable(rsp_brightness))
      else $error("stalled result item changed");

   // Brightness always follows the shade
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_brightness == bgpf_pkg::grey_level(rsp_shade))
      else $error("brightness does not match shade");

   // A query blocks the request channel for its two memory reads
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == bgpf_pkg::KIND_QUERY
      |=> req_stall ##1 req_stall)
      else $error("request taken while a query is in flight");

   // A memory write leaves the block ready for the next item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == bgpf_pkg::KIND_WRITE |=> !req_stall)
      else $error("write item stalled the request channel");

   // Reset leaves no result and an open request channel
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind background_tile_pixel_fetch_unit bgpf_checker u_bgpf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_color_index (rsp_color_index),
   .rsp_shade       (rsp_shade),
   .rsp_brightness  (rsp_brightness)
);

@@ dv/background_tile_pixel_fetch_unit_tb.sv @@
// Self-checking testbench for background_tile_pixel_fetch_unit: video memory writes and
// pixel queries, predicted in-bench and checked against every result item.
// Depends on bgpf_pkg (register indexes, item kinds) and the unit's RTL only.
module background_tile_pixel_fetch_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_LOW_BASE     = 'h1800;
   localparam int MAP_HIGH_BASE    = 'h1C00;
   localparam int SIGNED_TILE_BASE = 'h1000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_ITEMS      = 200;

   typedef logic [bgpf_pkg::CSR_INDEX_W-1:0] csr_index_type;

   typedef struct packed {
      logic [1:0] color_index;
      logic [1:0] shade;
      logic [7:0] brightness;
   } pixel_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = '0;
   logic [7:0]    csr_wr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_kind = bgpf_pkg::KIND_WRITE;
   logic [12:0]   req_mem_address = '0;
   logic [7:0]    req_mem_data = '0;
   logic [7:0]    req_screen_line = '0;
   logic [7:0]    req_screen_column = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_color_index;
   logic [1:0]    rsp_shade;
   logic [7:0]    rsp_brightness;

   // Shadow of the unit: video memory, which bytes hold data, and the registers
   logic [7:0] vram_model [bgpf_pkg::VRAM_BYTES];
   bit         vram_written [bgpf_pkg::VRAM_BYTES];
   logic [7:0] cfg_scroll_x = 8'd0;
   logic [7:0] cfg_scroll_y = 8'd0;
   logic       cfg_map_select = 1'b0;
   logic       cfg_tile_data_select = 1'b1;
   logic [7:0] cfg_bg_palette = 8'd0;

   pixel_type expected_pixels [$];
   int        errors = 0;
   int        items_sent = 0;
   bit        traffic_gaps = 1'b1;
   int        stall_left = 0;

   background_tile_pixel_fetch_unit uut (.*);

   always #4 clock = ~clock;

   // Coordinate after scroll, wrapping at 256
   function automatic int scrolled(input logic [7:0] pos, input logic [7:0] scroll);
      return (int'(pos) + int'(scroll)) & 255;
   endfunction

   function automatic int map_address(input logic [7:0] line, input logic [7:0] column);
      int y;
      int x;
      y = scrolled(line, cfg_scroll_y);
      x = scrolled(column, cfg_scroll_x);
      return (cfg_map_select ? MAP_HIGH_BASE : MAP_LOW_BASE) + (y >> 3) * 32 + (x >> 3);
   endfunction

   // Low-plane byte of a tile row; the high plane follows it
   function automatic int tile_row_address(input int tile, input int row);
      if (cfg_tile_data_select)
         return tile * 16 + row * 2;
      else if (tile < 128)
         return SIGNED_TILE_BASE + tile * 16 + row * 2;
      else
         return SIGNED_TILE_BASE - (256 - tile) * 16 + row * 2;
   endfunction

   function automatic pixel_type predict_pixel(input logic [7:0] line,
                                               input logic [7:0] column);
      pixel_type px;
      int        y;
      int        bitpos;
      int        row_addr;
      y        = scrolled(line, cfg_scroll_y);
      bitpos   = 7 - (scrolled(column, cfg_scroll_x) & 7);
      row_addr = tile_row_address(vram_model[map_address(line, column)], y & 7);
      px.color_index = {vram_model[row_addr + 1][bitpos], vram_model[row_addr][bitpos]};
      px.shade       = 2'(cfg_bg_palette >> (2 * px.color_index));
      px.brightness  = 8'(255 - 85 * px.shade);
      return px;
   endfunction

   // Drive one item at the falling edge, hold it until accepted, then update the shadow
   task automatic send_item(input logic kind, input logic [12:0] addr, input logic [7:0] data,
                            input logic [7:0] line, input logic [7:0] column);
      @(negedge clock);
      if (traffic_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_mem_address   <= addr;
      req_mem_data      <= data;
      req_screen_line   <= line;
      req_screen_column <= column;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (kind == bgpf_pkg::KIND_WRITE) begin
         vram_model[addr]   = data;
         vram_written[addr] = 1'b1;
      end else begin
         expected_pixels = {expected_pixels, predict_pixel(line, column)};
      end
   endtask

   task automatic store_byte(input int addr, input logic [7:0] data);
      send_item(bgpf_pkg::KIND_WRITE, 13'(addr), data, 8'($urandom), 8'($urandom));
   endtask

   // Query one pixel, first filling any map or tile row byte it would read
   task automatic fetch_pixel(input logic [7:0] line, input logic [7:0] column);
      int map_addr;
      int row_addr;
      map_addr = map_address(line, column);
      if (!vram_written[map_addr])
         store_byte(map_addr, 8'($urandom));
      row_addr = tile_row_address(vram_model[map_addr], scrolled(line, cfg_scroll_y) & 7);
      if (!vram_written[row_addr])
         store_byte(row_addr, 8'($urandom));
      if (!vram_written[row_addr + 1])
         store_byte(row_addr + 1, 8'($urandom));
      send_item(bgpf_pkg::KIND_QUERY, 13'($urandom), 8'($urandom), line, column);
   endtask

   // Write one register; the shadow keeps only the register's width
   task automatic write_csr(input csr_index_type index, input logic [7:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         bgpf_pkg::CSR_SCROLL_X:         cfg_scroll_x = value;
         bgpf_pkg::CSR_SCROLL_Y:         cfg_scroll_y = value;
         bgpf_pkg::CSR_MAP_SELECT:       cfg_map_select = value[0];
         bgpf_pkg::CSR_TILE_DATA_SELECT: cfg_tile_data_select = value[0];
         bgpf_pkg::CSR_BG_PALETTE:       cfg_bg_palette = value;
         default: ;
      endcase
   endtask

   task automatic write_all_csrs(input logic [7:0] sx, input logic [7:0] sy, input logic msel,
                                 input logic tsel, input logic [7:0] palette);
      write_csr(bgpf_pkg::CSR_SCROLL_X, sx);
      write_csr(bgpf_pkg::CSR_SCROLL_Y, sy);
      write_csr(bgpf_pkg::CSR_MAP_SELECT, {7'd0, msel});
      write_csr(bgpf_pkg::CSR_TILE_DATA_SELECT, {7'd0, tsel});
      write_csr(bgpf_pkg::CSR_BG_PALETTE, palette);
   endtask

   // Drop valid, wait for every expected pixel, then let the pipeline settle
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers at their reset values: palette zero maps every pixel to shade 0
   task automatic test_reset_values();
      fetch_pixel(8'd0, 8'd0);
      fetch_pixel(8'd143, 8'd159);
      fetch_pixel(8'd77, 8'd13);
      finish_phase();
   endtask

   // Signed tile numbers at both ends of each half of the range
   task automatic test_signed_tile_edges();
      logic [7:0] tiles [4] = '{8'd0, 8'd127, 8'd128, 8'd255};
      write_all_csrs(8'd0, 8'd0, 1'b0, 1'b0, 8'hE4);
      foreach (tiles[k]) begin
         store_byte(MAP_LOW_BASE + k * 32, tiles[k]);
         fetch_pixel(8'(k * 8 + 7), 8'd7);
      end
      finish_phase();
   endtask

   // Maximum scroll, high map, coordinates beyond the visible area, extreme addresses
   task automatic test_coordinate_extremes();
      write_all_csrs(8'd255, 8'd255, 1'b1, 1'b1, 8'h1B);
      store_byte(0, 8'd0);
      store_byte(bgpf_pkg::VRAM_BYTES - 1, 8'd255);
      fetch_pixel(8'd0, 8'd0);
      fetch_pixel(8'd255, 8'd255);
      fetch_pixel(8'd1, 8'd1);
      fetch_pixel(8'd143, 8'd159);
      finish_phase();
   endtask

   // Over-wide values on one-bit registers and writes to unused indexes
   task automatic test_register_masking();
      write_all_csrs(8'd3, 8'd250, 1'b0, 1'b1, 8'hFF);
      write_csr(bgpf_pkg::CSR_MAP_SELECT, 8'hFE);
      write_csr(bgpf_pkg::CSR_TILE_DATA_SELECT, 8'hFF);
      for (int k = bgpf_pkg::CSR_BG_PALETTE + 1; k < 2 ** bgpf_pkg::CSR_INDEX_W; k++)
         write_csr(csr_index_type'(k), 8'($urandom));
      repeat (4) fetch_pixel(8'($urandom), 8'($urandom));
      finish_phase();
      write_csr(bgpf_pkg::CSR_TILE_DATA_SELECT, 8'h02);
      write_csr(bgpf_pkg::CSR_BG_PALETTE, 8'h00);
      repeat (4) fetch_pixel(8'($urandom), 8'($urandom));
      finish_phase();
   endtask

   // Phases of mixed traffic, each under its own register setting; the last without gaps
   task automatic test_random_traffic();
      int stop_at;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       write_all_csrs(8'd255, 8'd255, 1'b1, 1'b0, 8'hFF);
            1:       write_all_csrs(8'd0, 8'd0, 1'b0, 1'b1, 8'h00);
            default: write_all_csrs(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                                    8'($urandom));
         endcase
         traffic_gaps = (phase != 5);
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            case ($urandom_range(0, 19))
               0, 1, 2:  store_byte($urandom_range(0, bgpf_pkg::VRAM_BYTES - 1),
                                    8'($urandom));
               3, 4:     fetch_pixel(8'($urandom), 8'($urandom));
               default:  fetch_pixel(8'($urandom_range(0, 143)), 8'($urandom_range(0, 159)));
            endcase
         end
         finish_phase();
      end
   endtask

   // Hold off results in random bursts, started only while traffic gaps are on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest expected pixel
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result: color_index %0d shade %0d brightness %0d",
                     $time, rsp_color_index, rsp_shade, rsp_brightness);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_color_index !== want.color_index) begin
               $display("%0t: color_index expected %0d actual %0d",
                        $time, want.color_index, rsp_color_index);
               errors++;
            end
            if (rsp_shade !== want.shade) begin
               $display("%0t: shade expected %0d actual %0d", $time, want.shade, rsp_shade);
               errors++;
            end
            if (rsp_brightness !== want.brightness) begin
               $display("%0t: brightness expected %0d actual %0d",
                        $time, want.brightness, rsp_brightness);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_signed_tile_edges();
      test_coordinate_extremes();
      test_register_masking();
      test_random_traffic();
      if (errors == 0) begin
         $display("background_tile_pixel_fetch_unit_tb passed");
      end else begin
         $display("background_tile_pixel_fetch_unit_tb failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("background_tile_pixel_fetch_unit_tb failed");
      $finish;
   end

endmodule
